// ===== hdl/i2c_master_bit_engine_assert.svh =====
// Assertion macros for the I2C master bit engine.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define I2CBE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("i2cbe: same-cycle check failed");

// Next-cycle implication
`define I2CBE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("i2cbe: next-cycle check failed");

`else

`define I2CBE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define I2CBE_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/i2cbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2cbe_pkg;

  // Field widths of the command and result words
  localparam int unsigned REQ_WIDTH         = 3;
  localparam int unsigned BYTE_WIDTH        = 8;
  localparam int unsigned HALF_PERIOD_WIDTH = 10;
  localparam int unsigned BIT_CNT_WIDTH     = 4;
  localparam int unsigned BITS_PER_BYTE     = 8;

  // Default width of the acknowledge timeout counter
  localparam int unsigned TIMEOUT_WIDTH     = 16;

  // Register reset values
  localparam int unsigned HALF_PERIOD_RESET = 4;
  localparam int unsigned ACK_TIMEOUT_RESET = 250;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_WIDTH = 1;
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_HALF_PERIOD = 1'b0,
    CFG_ACK_TIMEOUT = 1'b1
  } cfg_idx_e;

  // Command codes
  typedef enum logic [REQ_WIDTH-1:0] {
    REQ_START = 3'd0,
    REQ_STOP  = 3'd1,
    REQ_SEND  = 3'd2,
    REQ_ACK   = 3'd3,
    REQ_READ  = 3'd4
  } req_e;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ST1     = 4'd1,
    PH_ST2     = 4'd2,
    PH_SP1     = 4'd3,
    PH_SP2     = 4'd4,
    PH_TX_HI   = 4'd5,
    PH_TX_LO   = 4'd6,
    PH_TX_NEXT = 4'd7,
    PH_ACKWAIT = 4'd8,
    PH_RX_LO   = 4'd9,
    PH_RX_HI   = 4'd10,
    PH_RX_ACK  = 4'd11,
    PH_RA_HI   = 4'd12,
    PH_RA_LO   = 4'd13
  } phase_e;

  // One tick: sampled SDA plus an optional command
  typedef struct packed {
    logic                  cmd_valid;
    logic [REQ_WIDTH-1:0]  req_type;
    logic [BYTE_WIDTH-1:0] tx_byte;
    logic                  send_ack;
    logic                  sda_in;
  } cmd_t;

  // Bus levels and status after one tick
  typedef struct packed {
    logic                  scl_out;
    logic                  sda_out;
    logic                  sda_drive;
    logic                  busy_res;
    logic                  done_res;
    logic [BYTE_WIDTH-1:0] rx_byte;
    logic                  nack;
  } res_t;

  // Sequencer state, apart from the timeout counter
  typedef struct packed {
    phase_e                       phase;
    logic [BIT_CNT_WIDTH-1:0]     bit_count;
    logic [BYTE_WIDTH-1:0]        shift_reg;
    logic [HALF_PERIOD_WIDTH-1:0] delay_count;
    logic                         scl_level;
    logic                         sda_level;
    logic                         sda_dir;
    logic                         ack_mode;
    logic                         nack_flag;
    logic [BYTE_WIDTH-1:0]        rx_hold;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:       PH_IDLE,
    bit_count:   '0,
    shift_reg:   '0,
    delay_count: '0,
    scl_level:   1'b1,
    sda_level:   1'b1,
    sda_dir:     1'b1,
    ack_mode:    1'b0,
    nack_flag:   1'b0,
    rx_hold:     '0
  };

endpackage

`default_nettype wire

// ===== hdl/i2cbe_cmd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Command channel: one word per bus tick
interface i2cbe_cmd_if import i2cbe_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/i2cbe_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Result channel: one word per bus tick
interface i2cbe_res_if import i2cbe_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/i2cbe_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cbe_cfg_regs import i2cbe_pkg::*; #(
  parameter int unsigned TimeoutWidth = TIMEOUT_WIDTH,
  parameter int unsigned CfgDataWidth =
    (TimeoutWidth > HALF_PERIOD_WIDTH) ? TimeoutWidth : HALF_PERIOD_WIDTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         we_i,
  input  wire logic [CFG_IDX_WIDTH-1:0]     idx_i,
  input  wire logic [CfgDataWidth-1:0]      data_i,
  output logic      [HALF_PERIOD_WIDTH-1:0] half_period_o,
  output logic      [TimeoutWidth-1:0]      ack_timeout_o
);

  logic [HALF_PERIOD_WIDTH-1:0] half_period_q;
  logic [TimeoutWidth-1:0]      ack_timeout_q;

  // Capture register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_WIDTH'(HALF_PERIOD_RESET);
      ack_timeout_q <= TimeoutWidth'(ACK_TIMEOUT_RESET);
    end else if (we_i) begin
      unique case (idx_i)
        CFG_HALF_PERIOD: half_period_q <= data_i[HALF_PERIOD_WIDTH-1:0];
        CFG_ACK_TIMEOUT: ack_timeout_q <= data_i[TimeoutWidth-1:0];
        default: ;
      endcase
    end
  end

  assign half_period_o = half_period_q;
  assign ack_timeout_o = ack_timeout_q;

endmodule

`default_nettype wire

// ===== hdl/i2cbe_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cbe_step import i2cbe_pkg::*; #(
  parameter int unsigned TimeoutWidth = TIMEOUT_WIDTH
) (
  input  wire state_t                         state_i,
  input  wire logic   [TimeoutWidth-1:0]      wait_i,
  input  wire logic   [HALF_PERIOD_WIDTH-1:0] half_period_i,
  input  wire logic   [TimeoutWidth-1:0]      ack_timeout_i,
  input  wire cmd_t                           cmd_i,
  output state_t                              state_o,
  output logic        [TimeoutWidth-1:0]      wait_o,
  output res_t                                res_o
);

  logic [HALF_PERIOD_WIDTH-1:0] delay_load;
  logic [BIT_CNT_WIDTH-1:0]     bit_inc;
  logic [BYTE_WIDTH-1:0]        tx_shift;
  logic [BYTE_WIDTH-1:0]        rx_shift;
  logic                         bit_last;
  logic                         act;
  logic                         done;
  state_t                       st;

  // Zero half period behaves as a half period of one
  assign delay_load = (half_period_i == '0) ? HALF_PERIOD_WIDTH'(1) : half_period_i;

  assign bit_inc  = state_i.bit_count + BIT_CNT_WIDTH'(1);
  assign bit_last = (bit_inc >= BIT_CNT_WIDTH'(BITS_PER_BYTE));
  assign tx_shift = {state_i.shift_reg[BYTE_WIDTH-2:0], 1'b0};
  assign rx_shift = {state_i.shift_reg[BYTE_WIDTH-2:0], cmd_i.sda_in};

  // Advance the sequencer by one tick
  always_comb begin
    st     = state_i;
    wait_o = wait_i;
    act    = 1'b0;
    done   = 1'b0;

    if (state_i.phase == PH_IDLE) begin
      // Take a command only when idle at the start of the tick
      if (cmd_i.cmd_valid) begin
        unique case (cmd_i.req_type)
          REQ_START: begin
            st.sda_dir     = 1'b1;
            st.sda_level   = 1'b1;
            st.scl_level   = 1'b1;
            st.delay_count = delay_load;
            st.phase       = PH_ST1;
          end
          REQ_STOP: begin
            st.sda_dir     = 1'b1;
            st.scl_level   = 1'b0;
            st.sda_level   = 1'b0;
            st.delay_count = delay_load;
            st.phase       = PH_SP1;
          end
          REQ_SEND: begin
            st.sda_dir     = 1'b1;
            st.scl_level   = 1'b0;
            st.shift_reg   = cmd_i.tx_byte;
            st.bit_count   = '0;
            st.sda_level   = cmd_i.tx_byte[BYTE_WIDTH-1];
            st.delay_count = delay_load;
            st.phase       = PH_TX_HI;
          end
          REQ_ACK: begin
            st.sda_dir     = 1'b0;
            st.sda_level   = 1'b1;
            st.scl_level   = 1'b1;
            wait_o         = '0;
            st.nack_flag   = 1'b0;
            st.delay_count = '0;
            st.phase       = PH_ACKWAIT;
          end
          REQ_READ: begin
            st.sda_dir     = 1'b0;
            st.shift_reg   = '0;
            st.bit_count   = '0;
            st.ack_mode    = cmd_i.send_ack;
            st.scl_level   = 1'b0;
            st.delay_count = delay_load;
            st.phase       = PH_RX_HI;
          end
          default: ;
        endcase
      end
    end else begin
      // Count down the delay; act when it runs out
      if (state_i.delay_count != '0) begin
        st.delay_count = state_i.delay_count - HALF_PERIOD_WIDTH'(1);
      end
      act = (state_i.delay_count <= HALF_PERIOD_WIDTH'(1));
    end

    if (act) begin
      unique case (state_i.phase)
        PH_ST1: begin
          st.sda_level   = 1'b0;
          st.delay_count = delay_load;
          st.phase       = PH_ST2;
        end
        PH_ST2: begin
          st.scl_level = 1'b0;
          done         = 1'b1;
          st.phase     = PH_IDLE;
        end
        PH_SP1: begin
          st.scl_level   = 1'b1;
          st.sda_level   = 1'b1;
          st.delay_count = delay_load;
          st.phase       = PH_SP2;
        end
        PH_SP2: begin
          done     = 1'b1;
          st.phase = PH_IDLE;
        end
        PH_TX_HI: begin
          st.scl_level   = 1'b1;
          st.delay_count = delay_load;
          st.phase       = PH_TX_LO;
        end
        PH_TX_LO: begin
          st.scl_level   = 1'b0;
          st.delay_count = delay_load;
          st.phase       = PH_TX_NEXT;
        end
        PH_TX_NEXT: begin
          st.bit_count = bit_inc;
          st.shift_reg = tx_shift;
          if (bit_last) begin
            done     = 1'b1;
            st.phase = PH_IDLE;
          end else begin
            st.sda_level   = tx_shift[BYTE_WIDTH-1];
            st.delay_count = delay_load;
            st.phase       = PH_TX_HI;
          end
        end
        PH_ACKWAIT: begin
          if (!cmd_i.sda_in) begin
            st.scl_level = 1'b0;
            st.nack_flag = 1'b0;
            done         = 1'b1;
            st.phase     = PH_IDLE;
          end else if (wait_i >= ack_timeout_i) begin
            // Timed out: flag and release the bus with a stop
            st.nack_flag   = 1'b1;
            st.sda_dir     = 1'b1;
            st.scl_level   = 1'b0;
            st.sda_level   = 1'b0;
            st.delay_count = delay_load;
            st.phase       = PH_SP1;
          end else begin
            wait_o = wait_i + TimeoutWidth'(1);
          end
        end
        PH_RX_LO: begin
          st.scl_level   = 1'b0;
          st.delay_count = delay_load;
          st.phase       = PH_RX_HI;
        end
        PH_RX_HI: begin
          st.scl_level   = 1'b1;
          st.shift_reg   = rx_shift;
          st.bit_count   = bit_inc;
          st.delay_count = delay_load;
          st.phase       = bit_last ? PH_RX_ACK : PH_RX_LO;
        end
        PH_RX_ACK: begin
          st.scl_level   = 1'b0;
          st.sda_dir     = 1'b1;
          st.sda_level   = !state_i.ack_mode;
          st.delay_count = delay_load;
          st.phase       = PH_RA_HI;
        end
        PH_RA_HI: begin
          st.scl_level   = 1'b1;
          st.delay_count = delay_load;
          st.phase       = PH_RA_LO;
        end
        PH_RA_LO: begin
          st.scl_level = 1'b0;
          st.rx_hold   = state_i.shift_reg;
          done         = 1'b1;
          st.phase     = PH_IDLE;
        end
        default: begin
          st.phase       = PH_IDLE;
          st.delay_count = '0;
        end
      endcase
    end
  end

  assign state_o = st;

  // Drive the result word from the updated state
  assign res_o.scl_out   = st.scl_level;
  assign res_o.sda_out   = st.sda_level;
  assign res_o.sda_drive = st.sda_dir;
  assign res_o.busy_res  = (st.phase != PH_IDLE);
  assign res_o.done_res  = done;
  assign res_o.rx_byte   = st.rx_hold;
  assign res_o.nack      = st.nack_flag;

endmodule

`default_nettype wire

// ===== hdl/i2c_master_bit_engine.sv =====
// I2C master bit engine. Every command word is one bus tick carrying the sampled SDA level
// and, when cmd_valid is set, a start, stop, send byte, wait ack or read byte command; every
// tick yields exactly one result word with the SCL/SDA levels, the SDA drive enable and the
// busy, done, received byte and nack status. Commands that arrive while busy are dropped.
// One tick is taken per clock cycle unless the result stalls: the word is captured in an input
// register, then the single-pass step logic updates the sequencer state and fills the result
// register. A stalled result holds the sequencer; the input register still takes one more tick.
// The user must write half_period and ack_timeout through the register port only while no
// ticks are in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_bit_engine_assert.svh"

module i2c_master_bit_engine import i2cbe_pkg::*; #(
  parameter int unsigned TimeoutWidth = TIMEOUT_WIDTH,
  localparam int unsigned CfgDataWidth =
    (TimeoutWidth > HALF_PERIOD_WIDTH) ? TimeoutWidth : HALF_PERIOD_WIDTH
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  wire logic [CfgDataWidth-1:0]  cfg_data_i,
  i2cbe_cmd_if.sink                     cmd_i,
  i2cbe_res_if.source                   res_o
);

  logic [HALF_PERIOD_WIDTH-1:0] half_period;
  logic [TimeoutWidth-1:0]      ack_timeout;

  logic                    in_vld_q, in_vld_d;
  cmd_t                    in_q;
  logic                    out_vld_q, out_vld_d;
  res_t                    res_q;
  res_t                    res_d;
  state_t                  state_q, state_d;
  logic [TimeoutWidth-1:0] wait_q, wait_d;
  logic                    cmd_take;
  logic                    adv;

  i2cbe_cfg_regs #(
    .TimeoutWidth (TimeoutWidth),
    .CfgDataWidth (CfgDataWidth)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .we_i          (cfg_we_i),
    .idx_i         (cfg_idx_i),
    .data_i        (cfg_data_i),
    .half_period_o (half_period),
    .ack_timeout_o (ack_timeout)
  );

  i2cbe_step #(
    .TimeoutWidth (TimeoutWidth)
  ) u_step (
    .state_i       (state_q),
    .wait_i        (wait_q),
    .half_period_i (half_period),
    .ack_timeout_i (ack_timeout),
    .cmd_i         (in_q),
    .state_o       (state_d),
    .wait_o        (wait_d),
    .res_o         (res_d)
  );

  // Advance when a word is staged and the result slot is free or being taken
  assign adv         = in_vld_q && (!out_vld_q || res_o.ready);
  assign cmd_i.ready = !in_vld_q || adv;
  assign cmd_take    = cmd_i.valid && cmd_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (cmd_take) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Control and sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= STATE_RESET;
      wait_q    <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        state_q <= state_d;
        wait_q  <= wait_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_take) begin
      in_q <= cmd_i.data;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = out_vld_q;
  assign res_o.data  = res_q;

  // A command with a known code, taken while idle, leaves the sequencer busy
  `I2CBE_ASSERT_NXT(a_cmd_starts, clk_i, rst_ni, adv && (state_q.phase == PH_IDLE) && in_q.cmd_valid && (in_q.req_type <= REQ_READ), state_q.phase != PH_IDLE)

  // SDA is released only while idle, waiting for ack or receiving
  `I2CBE_ASSERT_IMP(a_sda_release, clk_i, rst_ni, !state_q.sda_dir, (state_q.phase == PH_IDLE) || (state_q.phase == PH_ACKWAIT) || (state_q.phase == PH_RX_LO) || (state_q.phase == PH_RX_HI) || (state_q.phase == PH_RX_ACK))

  // A stalled result freezes the sequencer
  `I2CBE_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, out_vld_q && !res_o.ready, $stable(state_q) && $stable(wait_q))

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import i2cbe_pkg::*;

  localparam int unsigned CFG_W =
    (TIMEOUT_WIDTH > HALF_PERIOD_WIDTH) ? TIMEOUT_WIDTH : HALF_PERIOD_WIDTH;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned TICK_TARGET  = 550;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef enum int {SDA_RANDOM, SDA_LOW, SDA_HIGH} sda_mode_e;

  // Bus sequencer mirror: steps once per accepted tick and queues the bus word it implies
  class bus_level_scoreboard;
    logic [HALF_PERIOD_WIDTH-1:0] half_period;
    logic [TIMEOUT_WIDTH-1:0]     ack_timeout;
    phase_e                       phase;
    logic [BIT_CNT_WIDTH-1:0]     bit_count;
    logic [BYTE_WIDTH-1:0]        shift_reg;
    logic [HALF_PERIOD_WIDTH-1:0] delay_count;
    logic [TIMEOUT_WIDTH-1:0]     wait_count;
    logic                         scl_level;
    logic                         sda_level;
    logic                         sda_dir;
    logic                         ack_mode;
    logic                         nack_flag;
    logic [BYTE_WIDTH-1:0]        rx_hold;
    res_t                         expected_levels[$];
    int unsigned                  failures;

    function new();
      half_period = HALF_PERIOD_WIDTH'(HALF_PERIOD_RESET);
      ack_timeout = TIMEOUT_WIDTH'(ACK_TIMEOUT_RESET);
      phase       = PH_IDLE;
      bit_count   = '0;
      shift_reg   = '0;
      delay_count = '0;
      wait_count  = '0;
      scl_level   = 1'b1;
      sda_level   = 1'b1;
      sda_dir     = 1'b1;
      ack_mode    = 1'b0;
      nack_flag   = 1'b0;
      rx_hold     = '0;
      failures    = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, int unsigned value);
      if (idx == CFG_HALF_PERIOD) begin
        half_period = value[HALF_PERIOD_WIDTH-1:0];
      end else begin
        ack_timeout = value[TIMEOUT_WIDTH-1:0];
      end
    endfunction

    // Load one bus delay; a zero period loads as a period of one
    function void reload();
      if (half_period == '0) begin
        delay_count = HALF_PERIOD_WIDTH'(1);
      end else begin
        delay_count = half_period;
      end
    endfunction

    function void enter_stop();
      sda_dir   = 1'b1;
      scl_level = 1'b0;
      sda_level = 1'b0;
      reload();
      phase = PH_SP1;
    endfunction

    function res_t advance_bus(cmd_t w);
      res_t r;
      logic done;
      bit   act;
      done = 1'b0;
      act  = 1'b1;
      // Take a command only when idle at the start of the tick
      if (phase == PH_IDLE) begin
        act = 1'b0;
        if (w.cmd_valid) begin
          case (w.req_type)
            REQ_START: begin
              sda_dir   = 1'b1;
              sda_level = 1'b1;
              scl_level = 1'b1;
              reload();
              phase = PH_ST1;
            end
            REQ_STOP: enter_stop();
            REQ_SEND: begin
              sda_dir   = 1'b1;
              scl_level = 1'b0;
              shift_reg = w.tx_byte;
              bit_count = '0;
              sda_level = w.tx_byte[7];
              reload();
              phase = PH_TX_HI;
            end
            REQ_ACK: begin
              sda_dir     = 1'b0;
              sda_level   = 1'b1;
              scl_level   = 1'b1;
              wait_count  = '0;
              nack_flag   = 1'b0;
              delay_count = '0;
              phase       = PH_ACKWAIT;
            end
            REQ_READ: begin
              sda_dir   = 1'b0;
              shift_reg = '0;
              bit_count = '0;
              ack_mode  = w.send_ack;
              scl_level = 1'b0;
              reload();
              phase = PH_RX_HI;
            end
            default: ;
          endcase
        end
      end else if (delay_count != '0) begin
        delay_count--;
        if (delay_count != '0) act = 1'b0;
      end

      // Run the action that ends the current delay
      if (act) begin
        case (phase)
          PH_ST1: begin
            sda_level = 1'b0;
            reload();
            phase = PH_ST2;
          end
          PH_ST2: begin
            scl_level = 1'b0;
            done      = 1'b1;
            phase     = PH_IDLE;
          end
          PH_SP1: begin
            scl_level = 1'b1;
            sda_level = 1'b1;
            reload();
            phase = PH_SP2;
          end
          PH_SP2: begin
            done  = 1'b1;
            phase = PH_IDLE;
          end
          PH_TX_HI: begin
            scl_level = 1'b1;
            reload();
            phase = PH_TX_LO;
          end
          PH_TX_LO: begin
            scl_level = 1'b0;
            reload();
            phase = PH_TX_NEXT;
          end
          PH_TX_NEXT: begin
            bit_count++;
            shift_reg = shift_reg << 1;
            if (bit_count >= BITS_PER_BYTE) begin
              done  = 1'b1;
              phase = PH_IDLE;
            end else begin
              sda_level = shift_reg[7];
              reload();
              phase = PH_TX_HI;
            end
          end
          PH_ACKWAIT: begin
            if (!w.sda_in) begin
              scl_level = 1'b0;
              nack_flag = 1'b0;
              done      = 1'b1;
              phase     = PH_IDLE;
            end else if (wait_count >= ack_timeout) begin
              nack_flag = 1'b1;
              enter_stop();
            end else begin
              wait_count++;
            end
          end
          PH_RX_LO: begin
            scl_level = 1'b0;
            reload();
            phase = PH_RX_HI;
          end
          PH_RX_HI: begin
            scl_level = 1'b1;
            shift_reg = {shift_reg[6:0], w.sda_in};
            bit_count++;
            reload();
            phase = (bit_count >= BITS_PER_BYTE) ? PH_RX_ACK : PH_RX_LO;
          end
          PH_RX_ACK: begin
            scl_level = 1'b0;
            sda_dir   = 1'b1;
            sda_level = !ack_mode;
            reload();
            phase = PH_RA_HI;
          end
          PH_RA_HI: begin
            scl_level = 1'b1;
            reload();
            phase = PH_RA_LO;
          end
          PH_RA_LO: begin
            scl_level = 1'b0;
            rx_hold   = shift_reg;
            done      = 1'b1;
            phase     = PH_IDLE;
          end
          default: begin
            phase       = PH_IDLE;
            delay_count = '0;
          end
        endcase
      end

      r.scl_out   = scl_level;
      r.sda_out   = sda_level;
      r.sda_drive = sda_dir;
      r.busy_res  = (phase != PH_IDLE);
      r.done_res  = done;
      r.rx_byte   = rx_hold;
      r.nack      = nack_flag;
      return r;
    endfunction

    function void note_tick(cmd_t w);
      expected_levels.push_back(advance_bus(w));
    endfunction

    function void check_levels(res_t got);
      res_t want;
      if (expected_levels.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("bus word %h arrived with nothing pending", got);
        end
        return;
      end
      want = expected_levels.pop_front();
      if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
          got.sda_drive !== want.sda_drive || got.busy_res !== want.busy_res ||
          got.done_res !== want.done_res || got.rx_byte !== want.rx_byte ||
          got.nack !== want.nack) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("bus word mismatch, scl/sda/drive/busy/done/rx/nack");
          $display("  expected %0b %0b %0b %0b %0b %02h %0b",
                   want.scl_out, want.sda_out, want.sda_drive, want.busy_res,
                   want.done_res, want.rx_byte, want.nack);
          $display("  got      %0b %0b %0b %0b %0b %02h %0b",
                   got.scl_out, got.sda_out, got.sda_drive, got.busy_res,
                   got.done_res, got.rx_byte, got.nack);
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  cfg_idx_e         cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  i2cbe_cmd_if cmd_ch ();
  i2cbe_res_if res_ch ();

  bus_level_scoreboard sb = new();

  int          ack_delay;
  sda_mode_e   sda_mode;
  int unsigned noise_pct;
  int unsigned ticks_sent = 0;
  int unsigned idle_cycles = 0;
  bit          cmd_burst = 1'b0;
  bit          res_burst = 1'b0;

  i2c_master_bit_engine u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .cmd_i      (cmd_ch),
    .res_o      (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check every accepted bus word against the oldest pending one
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) sb.check_levels(res_ch.data);
  end

  // Abort when no word moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: drop ready for a random gap before each word, with bursts of no gap
  initial begin : result_sink
    int unsigned gap;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) res_burst = !res_burst;
      gap = res_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        @(negedge clk);
        res_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  // Present one tick word after a random gap and hold it until taken
  task automatic drive_tick(cmd_t w);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) cmd_burst = !cmd_burst;
    gap = cmd_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= w;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_tick(w);
    ticks_sent++;
  endtask

  // Build a tick while a command runs: the slave answers acks per ack_delay
  function automatic cmd_t filler_word(int unsigned noise);
    cmd_t w;
    w.cmd_valid = ($urandom_range(0, 99) < noise);
    w.req_type  = 3'($urandom_range(0, 7));
    w.tx_byte   = 8'($urandom);
    w.send_ack  = 1'($urandom);
    if (sb.phase == PH_ACKWAIT) begin
      w.sda_in = (int'(sb.wait_count) < ack_delay);
    end else if (sda_mode == SDA_LOW) begin
      w.sda_in = 1'b0;
    end else if (sda_mode == SDA_HIGH) begin
      w.sda_in = 1'b1;
    end else begin
      w.sda_in = 1'($urandom);
    end
    return w;
  endfunction

  // Issue a command on an idle tick, then tick until the engine is idle again
  task automatic run_command(logic [REQ_WIDTH-1:0] req, logic [7:0] data, logic ack);
    cmd_t w;
    w           = filler_word(0);
    w.cmd_valid = 1'b1;
    w.req_type  = req;
    w.tx_byte   = data;
    w.send_ack  = ack;
    drive_tick(w);
    while (sb.phase != PH_IDLE) drive_tick(filler_word(noise_pct));
  endtask

  function automatic int pick_ack_delay();
    int limit;
    int d;
    limit = int'(sb.ack_timeout);
    case ($urandom_range(0, 5))
      0:       d = limit + 1;
      1:       d = limit;
      default: d = $urandom_range(0, (limit > 8) ? 8 : limit);
    endcase
    return d;
  endfunction

  task automatic run_ack(int d);
    ack_delay = d;
    run_command(REQ_ACK, 8'($urandom), 1'($urandom));
  endtask

  // One bus transfer: start, address, data bytes with acks, stop
  task automatic run_transfer();
    int unsigned n;
    bit          rd;
    n  = $urandom_range(1, 3);
    rd = 1'($urandom);
    run_command(REQ_START, 8'($urandom), 1'($urandom));
    run_command(REQ_SEND, {7'($urandom), rd}, 1'($urandom));
    run_ack(pick_ack_delay());
    for (int i = 0; i < n && !sb.nack_flag && ticks_sent < TICK_TARGET; i++) begin
      if (rd) begin
        run_command(REQ_READ, 8'($urandom), i != n - 1);
      end else begin
        run_command(REQ_SEND, 8'($urandom), 1'($urandom));
        run_ack(pick_ack_delay());
      end
    end
    if (!sb.nack_flag) run_command(REQ_STOP, 8'($urandom), 1'($urandom));
  endtask

  // Drop valid, wait for every pending word plus pipeline slack
  task automatic settle();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (sb.expected_levels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[CFG_W-1:0];
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(int unsigned period, int unsigned limit);
    settle();
    write_reg(CFG_HALF_PERIOD, period);
    write_reg(CFG_ACK_TIMEOUT, limit);
  endtask

  initial begin : stimulus
    int unsigned phase_goal;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_HALF_PERIOD;
    cfg_data     = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    res_ch.ready = 1'b0;
    ack_delay    = 0;
    sda_mode     = SDA_RANDOM;
    noise_pct    = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Reset timing: unknown codes, a full byte and a short ack
    for (int c = 5; c < 8; c++) run_command(3'(c), 8'($urandom), 1'($urandom));
    run_command(REQ_START, 8'h00, 1'b0);
    run_command(REQ_SEND, 8'hFF, 1'b0);
    run_ack(3);
    run_command(REQ_STOP, 8'h00, 1'b0);

    // Zero period and zero timeout: first high sample times out
    set_timing(0, 0);
    run_command(REQ_START, 8'h00, 1'b0);
    run_ack(1);
    run_ack(0);
    noise_pct = 100;
    run_command(REQ_SEND, 8'h00, 1'b1);
    noise_pct = 0;
    sda_mode = SDA_HIGH;
    run_command(REQ_READ, 8'h00, 1'b1);
    sda_mode = SDA_LOW;
    run_command(REQ_READ, 8'hFF, 1'b0);
    sda_mode = SDA_RANDOM;
    run_command(REQ_SEND, 8'h5A, 1'b0);
    run_command(REQ_STOP, 8'h00, 1'b0);

    // Widest settings: an ack wait never loads the period
    set_timing(1023, 65535);
    run_ack(5);
    run_ack(0);

    // Random transfers and loose commands over several timing settings
    set_timing(1, 1);
    while (ticks_sent < TICK_TARGET) begin
      phase_goal = ticks_sent + $urandom_range(80, 140);
      while (ticks_sent < phase_goal && ticks_sent < TICK_TARGET) begin
        noise_pct = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100) : 0;
        if ($urandom_range(0, 4) != 0) begin
          run_transfer();
        end else begin
          ack_delay = pick_ack_delay();
          run_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
        end
      end
      case ($urandom_range(0, 3))
        0:       set_timing(1, $urandom_range(0, 6));
        1:       set_timing(2, $urandom_range(7, 40));
        2:       set_timing(3, $urandom_range(0, 6));
        default: set_timing($urandom_range(1, 3), $urandom_range(0, 40));
      endcase
    end

    settle();
    if (sb.failures == 0 && sb.expected_levels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/i2cbe_pkg.sv
hdl/i2cbe_cmd_if.sv
hdl/i2cbe_res_if.sv
hdl/i2cbe_cfg_regs.sv
hdl/i2cbe_step.sv
hdl/i2c_master_bit_engine.sv
tb/sv/testbench.sv
